// File: src/lzhw_pkg.sv
// Package with shared constants and types for the LZ history window copy block.
`default_nettype none
package lzhw_pkg;

  localparam int WINDOW_SIZE_DEF = 32768;
  localparam int MAX_LENGTH_DEF  = 64;

  typedef enum logic [1:0] {
    OP_LITERAL = 2'd0,
    OP_COPY    = 2'd1,
    OP_EOF     = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_t;

  // Commands from the sequencer to the window unit.
  typedef struct packed {
    logic        clear;
    logic        rd_en;
    logic [15:0] back_dist;
    logic        wr_en;
    logic [7:0]  wr_data;
  } win_cmd_t;

  // Registered read result of the window unit.
  typedef struct packed {
    logic       zero;
    logic [7:0] data;
  } win_rsp_t;

endpackage
`default_nettype wire

// File: src/lzhw_in_if.sv
// Input channel interface: operation items for the history window.
`default_nettype none
interface lzhw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  literal_byte;
  logic [15:0] distance;
  logic [6:0]  copy_length;

  modport source (output valid, output operation, output literal_byte,
                  output distance, output copy_length, input ready);
  modport sink (input valid, input operation, input literal_byte,
                input distance, input copy_length, output ready);
endinterface
`default_nettype wire

// File: src/lzhw_out_if.sv
// Output channel interface: decompressed bytes.
`default_nettype none
interface lzhw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

// File: src/lzhw_window.sv
// History window: byte memory, write position, fill count and source address unit.
`default_nettype none
module lzhw_window #(
  parameter int WINDOW_SIZE = lzhw_pkg::WINDOW_SIZE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lzhw_pkg::win_cmd_t cmd,
  output lzhw_pkg::win_rsp_t     rsp
);

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam int FW = $clog2(WINDOW_SIZE + 1);
  localparam int SW = AW + 2;
  localparam logic [SW-1:0] WIN_S   = SW'(WINDOW_SIZE);
  localparam logic [AW-1:0] WP_LAST = AW'(WINDOW_SIZE - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(WINDOW_SIZE);

  logic [7:0]    mem [WINDOW_SIZE];
  logic [AW-1:0] wp;
  logic [AW-1:0] wp_next;
  logic [FW-1:0] filled;
  logic [FW-1:0] filled_next;
  logic [SW-1:0] back_sum;
  logic [AW-1:0] rd_addr;
  logic          src_unwritten;

  // Source slot: wp - back_dist modulo window, one compare and subtract.
  always_comb begin
    back_sum = SW'(wp) + WIN_S - SW'(cmd.back_dist);
    if (back_sum >= WIN_S) begin
      rd_addr = AW'(back_sum - WIN_S);
    end else begin
      rd_addr = AW'(back_sum);
    end
    src_unwritten = (cmd.back_dist == 16'd0) || (32'(cmd.back_dist) > 32'(filled));
  end

  always_comb begin
    wp_next     = wp;
    filled_next = filled;
    if (cmd.clear) begin
      wp_next     = '0;
      filled_next = '0;
    end else if (cmd.wr_en) begin
      wp_next = (wp == WP_LAST) ? '0 : wp + 1'b1;
      if (filled != FILL_MAX) begin
        filled_next = filled + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      filled <= '0;
    end else begin
      wp     <= wp_next;
      filled <= filled_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wp] <= cmd.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rsp.data <= mem[rd_addr];
      rsp.zero <= src_unwritten;
    end
  end

endmodule
`default_nettype wire

// File: src/lzhw_seq.sv
// Sequencer: takes items, steps copies byte by byte, holds the output register.
`default_nettype none
module lzhw_seq #(
  parameter int MAX_LENGTH = lzhw_pkg::MAX_LENGTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  lzhw_in_if.sink                 in_item,
  lzhw_out_if.source              out_item,
  output lzhw_pkg::win_cmd_t      cmd,
  input  wire lzhw_pkg::win_rsp_t rsp
);

  localparam int CW = $clog2(MAX_LENGTH + 1);
  localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LENGTH);
  localparam logic [CW-1:0] ONE     = CW'(1);

  lzhw_pkg::state_t state;
  lzhw_pkg::state_t state_next;

  logic [CW-1:0] remaining;
  logic [CW-1:0] len_sat;
  logic [15:0]   back_dist;
  logic [7:0]    lit_byte;
  logic          is_lit;
  logic          out_valid;
  logic [7:0]    out_data;
  logic          out_last;
  logic          accept;
  logic          out_free;
  logic          emit;
  logic [7:0]    emit_byte;

  assign accept   = in_item.valid && in_item.ready;
  assign out_free = !out_valid || out_item.ready;
  assign emit     = (state == lzhw_pkg::ST_WRITE) && out_free;
  assign len_sat  = (in_item.copy_length > 7'(MAX_LENGTH)) ? LEN_MAX
                                                         : CW'(in_item.copy_length);
  assign emit_byte = is_lit ? lit_byte : (rsp.zero ? 8'd0 : rsp.data);

  always_comb begin
    state_next = state;
    case (state)
      lzhw_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_item.operation)
            lzhw_pkg::OP_LITERAL: state_next = lzhw_pkg::ST_WRITE;
            lzhw_pkg::OP_COPY: begin
              if (len_sat != '0) begin
                state_next = lzhw_pkg::ST_READ;
              end
            end
            default: state_next = lzhw_pkg::ST_IDLE;
          endcase
        end
      end
      lzhw_pkg::ST_READ: state_next = lzhw_pkg::ST_WRITE;
      lzhw_pkg::ST_WRITE: begin
        if (out_free) begin
          state_next = (remaining == ONE) ? lzhw_pkg::ST_IDLE : lzhw_pkg::ST_READ;
        end
      end
      default: state_next = lzhw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_item.ready = (state == lzhw_pkg::ST_IDLE) && !rst;
    cmd.clear     = accept && (in_item.operation == lzhw_pkg::OP_EOF);
    cmd.rd_en     = (state == lzhw_pkg::ST_READ);
    cmd.back_dist = back_dist;
    cmd.wr_en     = emit;
    cmd.wr_data   = emit_byte;
  end

  assign out_item.valid    = out_valid;
  assign out_item.out_byte = out_data;
  assign out_item.last     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lzhw_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_item.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lit_byte  <= in_item.literal_byte;
      back_dist <= in_item.distance;
      is_lit    <= (in_item.operation == lzhw_pkg::OP_LITERAL);
      remaining <= (in_item.operation == lzhw_pkg::OP_LITERAL) ? ONE : len_sat;
    end else if (emit) begin
      remaining <= remaining - 1'b1;
    end
    if (emit) begin
      out_data <= emit_byte;
      out_last <= (remaining == ONE);
    end
  end

endmodule
`default_nettype wire

// File: src/lz_history_window_copy.sv
// Top level of the LZ history window copy block.
//
//   channel   | dir | payload                                          | transfer
//   in_item   | in  | operation, literal_byte, distance, copy_length   | valid & ready
//   out_item  | out | out_byte, last                                   | valid & ready
//
// A literal is transferred, then written and emitted; a copy is transferred, then
// steps through each byte with a memory read, then a write and emit; end of file
// and unused codes take only the transfer. The registered window read sets the
// read-then-write byte step. Reset empties the window at once through the fill count.
// A stalled output holds the sequencer in its write step; input is taken only
// when no item is in progress, while the last byte may still wait at the output.
`default_nettype none
module lz_history_window_copy #(
  parameter int WINDOW_SIZE = lzhw_pkg::WINDOW_SIZE_DEF,
  parameter int MAX_LENGTH  = lzhw_pkg::MAX_LENGTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  lzhw_in_if.sink    in_item,
  lzhw_out_if.source out_item
);

  lzhw_pkg::win_cmd_t cmd;
  lzhw_pkg::win_rsp_t rsp;

  lzhw_seq #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .out_item (out_item),
    .cmd      (cmd),
    .rsp      (rsp)
  );

  lzhw_window #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_window (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

endmodule
`default_nettype wire

// File: src/lzhw_check.sv
// Port-level checker for the LZ history window copy block, with its bind.
`default_nettype none
module lzhw_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_operation,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_byte,
  input wire logic        out_last
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_lit_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer && in_operation == lzhw_pkg::OP_LITERAL |=> !in_ready)
    else $error("ready while a literal is in progress");

  a_eof_idle: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (in_operation == lzhw_pkg::OP_EOF || in_operation == lzhw_pkg::OP_UNUSED)
    |=> in_ready)
    else $error("not ready after an item that emits nothing");

endmodule

bind lz_history_window_copy lzhw_check u_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_item.valid),
  .in_ready     (in_item.ready),
  .in_operation (in_item.operation),
  .out_valid    (out_item.valid),
  .out_ready    (out_item.ready),
  .out_byte     (out_item.out_byte),
  .out_last     (out_item.last)
);
`default_nettype wire

// File: tb/tb_lz_history_window_copy.sv
// Testbench for lz_history_window_copy: directed and random items checked against a byte model.
module tb_lz_history_window_copy;

  localparam int WIN = lzhw_pkg::WINDOW_SIZE_DEF;
  localparam int MAXLEN = lzhw_pkg::MAX_LENGTH_DEF;
  localparam int RAND_ITEMS = 220;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  lit;
    logic [15:0] back_dist;
    logic [6:0]  len;
    bit          drain;
  } op_item_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  logic clk;
  logic rst;

  lzhw_in_if in_ch ();
  lzhw_out_if out_ch ();

  lz_history_window_copy DUT (
    .clk(clk),
    .rst(rst),
    .in_item(in_ch),
    .out_item(out_ch)
  );

  // Byte model of the window
  logic [7:0] win_hist [WIN];
  int unsigned wr_pos = 0;
  int unsigned fill_cnt = 0;

  op_item_t pend_q [$];
  out_beat_t byte_q [$];

  int errors = 0;
  int n_lit = 0;
  int n_copy = 0;
  int n_eof = 0;
  int n_ign = 0;
  int n_bytes = 0;
  int n_wraps = 0;
  int unsigned gen_fill = 0;

  bit in_xfer = 1'b0;
  bit steady = 1'b0;
  int in_gap = 0;
  int out_stall = 0;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.operation = lzhw_pkg::OP_LITERAL;
    in_ch.literal_byte = 8'h00;
    in_ch.distance = 16'h0000;
    in_ch.copy_length = 7'h00;
    out_ch.ready = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_lz_history_window_copy NOT OK");
    $finish;
  end

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 50)
      $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic void store_byte(logic [7:0] b);
    win_hist[wr_pos] = b;
    if (wr_pos == WIN - 1) begin
      wr_pos = 0;
      n_wraps++;
    end else begin
      wr_pos++;
    end
    if (fill_cnt < WIN)
      fill_cnt++;
  endfunction

  task automatic decode_item(op_item_t it);
    int unsigned n;
    logic [7:0] b;
    out_beat_t e;
    case (it.op)
      lzhw_pkg::OP_LITERAL: begin
        store_byte(it.lit);
        e.data = it.lit;
        e.last = 1'b1;
        byte_q.insert(byte_q.size(), e);
        n_lit++;
      end
      lzhw_pkg::OP_COPY: begin
        n = (it.len > MAXLEN) ? MAXLEN : it.len;
        for (int k = 0; k < n; k++) begin
          // a source older than the current file reads as zero
          if (it.back_dist == 0 || it.back_dist > fill_cnt)
            b = 8'h00;
          else
            b = win_hist[(wr_pos + WIN - it.back_dist) % WIN];
          store_byte(b);
          e.data = b;
          e.last = (k == n - 1);
          byte_q.insert(byte_q.size(), e);
        end
        n_copy++;
      end
      lzhw_pkg::OP_EOF: begin
        wr_pos = 0;
        fill_cnt = 0;
        n_eof++;
      end
      default: n_ign++;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Monitor: check output transfers, feed input transfers to the model
  always @(posedge clk) begin
    out_beat_t e;
    op_item_t it;
    in_xfer = 1'b0;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (byte_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %h last %b", out_ch.out_byte,
                                    out_ch.last));
        end else begin
          e = byte_q.pop_front();
          n_bytes++;
          if (out_ch.out_byte !== e.data)
            report_mismatch($sformatf("out_byte %h, want %h", out_ch.out_byte, e.data));
          if (out_ch.last !== e.last)
            report_mismatch($sformatf("last %b, want %b (byte %h)", out_ch.last, e.last,
                                      e.data));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        in_xfer = 1'b1;
        it.op = in_ch.operation;
        it.lit = in_ch.literal_byte;
        it.back_dist = in_ch.distance;
        it.len = in_ch.copy_length;
        it.drain = 1'b0;
        decode_item(it);
      end
    end
  end

  // Driver: input items with gaps, output ready with stalls
  always @(negedge clk) begin
    op_item_t it;
    logic nv;
    nv = in_ch.valid;
    if ($urandom_range(0, 499) == 0)
      steady = !steady;
    if (rst) begin
      nv = 1'b0;
    end else if (!in_ch.valid || in_xfer) begin
      nv = 1'b0;
      if (in_xfer && !steady)
        in_gap = pick_gap();
      if (in_gap > 0) begin
        in_gap--;
      end else if (pend_q.size() > 0 && (!pend_q[0].drain || byte_q.size() == 0)) begin
        // a drain item holds until every expected byte is out
        it = pend_q.pop_front();
        in_ch.operation <= it.op;
        in_ch.literal_byte <= it.lit;
        in_ch.distance <= it.back_dist;
        in_ch.copy_length <= it.len;
        nv = 1'b1;
      end
    end
    in_ch.valid <= nv;

    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0)
        out_stall = pick_gap();
    end
  end

  task automatic queue_item(logic [1:0] op, logic [7:0] lit, logic [15:0] back_dist,
                            logic [6:0] len, bit drain);
    op_item_t it;
    it.op = op;
    it.lit = lit;
    it.back_dist = back_dist;
    it.len = len;
    it.drain = drain;
    pend_q.insert(pend_q.size(), it);
    case (op)
      lzhw_pkg::OP_LITERAL: gen_fill++;
      lzhw_pkg::OP_COPY: gen_fill += (len > MAXLEN) ? MAXLEN : len;
      lzhw_pkg::OP_EOF: gen_fill = 0;
      default: ;
    endcase
    if (gen_fill > WIN)
      gen_fill = WIN;
  endtask

  // Copy whose source lies inside the current file, once the file holds a byte
  task automatic queue_copy(logic [6:0] len);
    int unsigned top;
    top = (gen_fill == 0) ? 1 : gen_fill;
    queue_item(lzhw_pkg::OP_COPY, 8'($urandom), 16'($urandom_range(1, top)), len, 1'b0);
  endtask

  initial begin
    int n_rand;
    int r;
    n_rand = 0;

    // directed part
    queue_item(lzhw_pkg::OP_LITERAL, 8'h00, 16'($urandom), 7'($urandom), 1'b0);
    queue_item(lzhw_pkg::OP_LITERAL, 8'hFF, 16'($urandom), 7'($urandom), 1'b0);
    queue_item(lzhw_pkg::OP_COPY, 8'($urandom), 16'd1, 7'd1, 1'b0);
    queue_item(lzhw_pkg::OP_COPY, 8'($urandom), 16'd2, 7'd64, 1'b0);
    queue_item(lzhw_pkg::OP_COPY, 8'($urandom), 16'd1, 7'd0, 1'b0);
    queue_item(lzhw_pkg::OP_COPY, 8'($urandom), 16'd3, 7'd127, 1'b0);
    queue_item(lzhw_pkg::OP_COPY, 8'($urandom), 16'd0, 7'd3, 1'b0);
    // source starts before the file and runs into written bytes
    queue_item(lzhw_pkg::OP_COPY, 8'($urandom), 16'd150, 7'd30, 1'b0);
    queue_item(lzhw_pkg::OP_COPY, 8'($urandom), 16'hFFFF, 7'd4, 1'b0);
    queue_item(lzhw_pkg::OP_COPY, 8'($urandom), 16'd32768, 7'd2, 1'b0);
    queue_item(lzhw_pkg::OP_UNUSED, 8'($urandom), 16'($urandom), 7'($urandom), 1'b0);
    queue_item(lzhw_pkg::OP_LITERAL, 8'hA5, 16'($urandom), 7'($urandom), 1'b1);
    queue_item(lzhw_pkg::OP_EOF, 8'($urandom), 16'($urandom), 7'($urandom), 1'b1);
    queue_item(lzhw_pkg::OP_COPY, 8'($urandom), 16'd1, 7'd4, 1'b0);
    queue_item(lzhw_pkg::OP_LITERAL, 8'h5A, 16'($urandom), 7'($urandom), 1'b0);
    queue_item(lzhw_pkg::OP_COPY, 8'($urandom), 16'd1, 7'd64, 1'b0);
    queue_item(lzhw_pkg::OP_COPY, 8'($urandom), 16'd69, 7'd7, 1'b0);
    queue_item(lzhw_pkg::OP_COPY, 8'($urandom), 16'h8001, 7'd2, 1'b0);
    queue_item(lzhw_pkg::OP_LITERAL, 8'($urandom), 16'($urandom), 7'($urandom), 1'b0);
    queue_item(lzhw_pkg::OP_EOF, 8'($urandom), 16'($urandom), 7'($urandom), 1'b0);
    queue_item(lzhw_pkg::OP_COPY, 8'($urandom), 16'h7FFF, 7'h40, 1'b0);
    queue_item(lzhw_pkg::OP_EOF, 8'($urandom), 16'($urandom), 7'($urandom), 1'b0);

    // random part: files of literals and copies, with some noise
    while (n_rand < RAND_ITEMS) begin
      repeat ($urandom_range(1, 6)) begin
        queue_item(lzhw_pkg::OP_LITERAL, 8'($urandom), 16'($urandom), 7'($urandom), 1'b0);
        n_rand++;
      end
      r = 0;
      while (r < 95 && n_rand < RAND_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 25) begin
          queue_item(lzhw_pkg::OP_LITERAL, 8'($urandom), 16'($urandom), 7'($urandom),
                     1'b0);
        end else if (r < 75) begin
          queue_copy(7'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 16)
                                                      : $urandom_range(17, 64)));
        end else if (r < 85) begin
          queue_item(lzhw_pkg::OP_COPY, 8'($urandom), 16'($urandom), 7'($urandom), 1'b0);
        end else if (r < 90) begin
          queue_item(lzhw_pkg::OP_UNUSED, 8'($urandom), 16'($urandom), 7'($urandom),
                     1'b0);
          n_rand--;
        end else if (r < 95) begin
          queue_item(lzhw_pkg::OP_COPY, 8'($urandom), 16'($urandom_range(0, gen_fill + 20)),
                     7'($urandom_range(1, 20)), 1'b0);
        end else begin
          queue_item(lzhw_pkg::OP_EOF, 8'($urandom), 16'($urandom), 7'($urandom),
                     $urandom_range(0, 2) == 0);
        end
        n_rand++;
      end
    end
    queue_item(lzhw_pkg::OP_LITERAL, 8'($urandom), 16'($urandom), 7'($urandom), 1'b0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pend_q.size() != 0 || in_ch.valid)
      @(posedge clk);
    while (byte_q.size() != 0)
      @(posedge clk);
    repeat (4 * MAXLEN) @(posedge clk);

    $display("Covered %0d literals, %0d copies, %0d end-of-file items, %0d unused codes.",
             n_lit, n_copy, n_eof, n_ign);
    $display("Checked %0d output bytes; the window write position wrapped %0d times.",
             n_bytes, n_wraps);
    if (errors == 0)
      $display("tb_lz_history_window_copy OK");
    else
      $display("tb_lz_history_window_copy NOT OK");
    $finish;
  end

endmodule
